>>> sv/coverage_trace_recorder_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the coverage trace recorder
// Shorthands for clocked properties under the asynchronous reset.
// ----------------------------------------------------------------------------
`ifndef COVERAGE_TRACE_RECORDER_ASSERT_SVH
`define COVERAGE_TRACE_RECORDER_ASSERT_SVH

// Same-cycle implication, checked at every rising edge out of reset
`define COVTR_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked at every rising edge out of reset
`define COVTR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> sv/covtr_pkg.sv
// ----------------------------------------------------------------------------
// covtr_pkg
// Request, mode and register codes, and the command and status bundles
// passed between the recorder controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package covtr_pkg;

	// request codes
	localparam logic [1:0] REQ_LOC  = 2'd0;
	localparam logic [1:0] REQ_CMP  = 2'd1;
	localparam logic [1:0] REQ_READ = 2'd2;

	// trace modes
	localparam logic [1:0] MODE_LOC  = 2'd1;
	localparam logic [1:0] MODE_CMP  = 2'd2;
	localparam logic [1:0] MODE_EDGE = 2'd3;

	// configuration register indexes
	localparam logic [1:0] REG_MODE   = 2'd0;
	localparam logic [1:0] REG_AREA   = 2'd1;
	localparam logic [1:0] REG_OFFSET = 2'd2;

	// width of the area register and its reset value
	localparam int unsigned AREA_W = 13;
	localparam logic [AREA_W-1:0] AREA_RESET = 13'd4096;

	// smallest area that holds the count word and one comparison record
	localparam logic [AREA_W-1:0] CMP_REC_MIN = 13'd5;
	// log2 of the words in one comparison record
	localparam int unsigned CMP_SHIFT = 2;

	// edge hash multiplier
	localparam logic [63:0] HASH_MULT = 64'h61C8864680B583EB;

	// words of one comparison record, in write order
	localparam logic [1:0] CW_TYPE = 2'd0;
	localparam logic [1:0] CW_A    = 2'd1;
	localparam logic [1:0] CW_B    = 2'd2;
	localparam logic [1:0] CW_LOC  = 2'd3;

	// partial product steps of the hash multiply
	localparam logic [1:0] MUL_LL  = 2'd0;
	localparam logic [1:0] MUL_HL  = 2'd1;
	localparam logic [1:0] MUL_LH  = 2'd2;
	localparam logic [1:0] MUL_SUM = 2'd3;

	// operation class of an accepted item
	typedef logic [2:0] covtr_kind_t;
	localparam covtr_kind_t KIND_NONE = 3'd0;
	localparam covtr_kind_t KIND_READ = 3'd1;
	localparam covtr_kind_t KIND_EDGE = 3'd2;
	localparam covtr_kind_t KIND_LOC  = 3'd3;
	localparam covtr_kind_t KIND_CMP  = 3'd4;

	typedef struct packed {
		logic       accept;
		logic       clear;
		logic       exec;
		logic       mul_en;
		logic [1:0] mul_ph;
		logic       wr_data;
		logic [1:0] wsel;
		logic       wr_cnt;
		logic       load_out;
	} covtr_cmd_t;

	typedef struct packed {
		covtr_kind_t kind;
		logic        rec;
		logic        clr_last;
	} covtr_sts_t;

endpackage

`default_nettype wire

>>> sv/coverage_trace_recorder.sv
// ----------------------------------------------------------------------------
// coverage_trace_recorder
// Coverage memory that records edge counts, location traces or comparison
// records, and reads back one word per request.
//
//   channel | dir | handshake              | payload
//   --------+-----+------------------------+-------------------------------
//   in      | in  | in_valid / in_ready    | req_type .. read_index
//   out     | out | out_valid / out_ready  | read_data, recorded, flush_request
//   cfg     | in  | cfg_wr_en (no wait)    | cfg_index, cfg_wdata
//
// Items are taken one at a time, each in steps that share the single memory
// port: reads and ignored events, location traces, edge bitmap updates (four
// steps of the shared 32x32 hash multiplier) and comparison records; a trace
// event that finds no room writes nothing.
// After reset a clearing pass writes zero to all AREA_DEPTH words, one per
// cycle; in_ready stays low until the pass ends.
// A result waits in the output register while the next item is taken in.
// ----------------------------------------------------------------------------
`default_nettype none

module coverage_trace_recorder #(
	parameter int unsigned AREA_DEPTH = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  req_type,
	input  logic        in_task_context,
	input  logic [63:0] location,
	input  logic [2:0]  cmp_type,
	input  logic [63:0] operand_a,
	input  logic [63:0] operand_b,
	input  logic [11:0] read_index,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] read_data,
	output logic        recorded,
	output logic        flush_request,
	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_wdata
);

	covtr_pkg::covtr_cmd_t cmd;
	covtr_pkg::covtr_sts_t sts;

	// sequencer
	covtr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// memory and arithmetic
	covtr_datapath #(
		.AREA_DEPTH (AREA_DEPTH)
	) u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_index       (cfg_index),
		.cfg_wdata       (cfg_wdata),
		.req_type        (req_type),
		.in_task_context (in_task_context),
		.location        (location),
		.cmp_type        (cmp_type),
		.operand_a       (operand_a),
		.operand_b       (operand_b),
		.read_index      (read_index),
		.read_data       (read_data),
		.recorded        (recorded),
		.flush_request   (flush_request)
	);

endmodule

`default_nettype wire

>>> sv/covtr_ctrl.sv
// ----------------------------------------------------------------------------
// covtr_ctrl
// Sequencer for the recorder: clearing sweep, item acceptance, memory
// write steps, hash multiply steps and hand-off to the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module covtr_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	output logic                  out_valid,
	input  logic                  out_ready,
	input  covtr_pkg::covtr_sts_t sts,
	output covtr_pkg::covtr_cmd_t cmd
);

	localparam logic [3:0] ST_CLEAR = 4'd0;
	localparam logic [3:0] ST_IDLE  = 4'd1;
	localparam logic [3:0] ST_EXEC  = 4'd2;
	localparam logic [3:0] ST_MUL1  = 4'd3;
	localparam logic [3:0] ST_MUL2  = 4'd4;
	localparam logic [3:0] ST_MUL3  = 4'd5;
	localparam logic [3:0] ST_WDATA = 4'd6;
	localparam logic [3:0] ST_WCNT  = 4'd7;
	localparam logic [3:0] ST_DONE  = 4'd8;

	logic [3:0] state_q, state_d;
	logic [1:0] wsel_q, wsel_d;
	logic       out_valid_q, out_valid_d;
	logic       out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	// next state and commands
	always_comb begin
		cmd     = '0;
		state_d = state_q;
		wsel_d  = wsel_q;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clear = 1'b1;
				if (sts.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
				wsel_d   = covtr_pkg::CW_TYPE;
				priority if (sts.kind == covtr_pkg::KIND_EDGE) begin
					cmd.mul_en = 1'b1;
					cmd.mul_ph = covtr_pkg::MUL_LL;
					state_d    = ST_MUL1;
				end else if (sts.kind == covtr_pkg::KIND_LOC ||
						sts.kind == covtr_pkg::KIND_CMP) begin
					state_d = ST_WDATA;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_MUL1: begin
				cmd.mul_en = 1'b1;
				cmd.mul_ph = covtr_pkg::MUL_HL;
				state_d    = ST_MUL2;
			end
			ST_MUL2: begin
				cmd.mul_en = 1'b1;
				cmd.mul_ph = covtr_pkg::MUL_LH;
				state_d    = ST_MUL3;
			end
			ST_MUL3: begin
				cmd.mul_en = 1'b1;
				cmd.mul_ph = covtr_pkg::MUL_SUM;
				state_d    = ST_DONE;
			end
			ST_WDATA: begin
				if (sts.rec) begin
					cmd.wr_data = 1'b1;
					cmd.wsel    = wsel_q;
					if (sts.kind == covtr_pkg::KIND_LOC || wsel_q == covtr_pkg::CW_LOC) begin
						state_d = ST_WCNT;
					end else begin
						wsel_d = wsel_q + 2'd1;
					end
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_WCNT: begin
				cmd.wr_cnt = 1'b1;
				state_d    = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// hold the result valid until transfer
	always_comb begin
		out_valid_d = out_valid_q;
		priority if (cmd.load_out) begin
			out_valid_d = 1'b1;
		end else if (out_ready) begin
			out_valid_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			wsel_q      <= covtr_pkg::CW_TYPE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			wsel_q      <= wsel_d;
			out_valid_q <= out_valid_d;
		end
	end

endmodule

`default_nettype wire

>>> sv/covtr_datapath.sv
// ----------------------------------------------------------------------------
// covtr_datapath
// Configuration registers, coverage memory (single port), item capture,
// edge byte update, trace append arithmetic, hash multiplier and the
// result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module covtr_datapath #(
	parameter int unsigned AREA_DEPTH = 4096
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  covtr_pkg::covtr_cmd_t cmd,
	output covtr_pkg::covtr_sts_t sts,
	input  logic                  cfg_wr_en,
	input  logic [1:0]            cfg_index,
	input  logic [63:0]           cfg_wdata,
	input  logic [1:0]            req_type,
	input  logic                  in_task_context,
	input  logic [63:0]           location,
	input  logic [2:0]            cmp_type,
	input  logic [63:0]           operand_a,
	input  logic [63:0]           operand_b,
	input  logic [11:0]           read_index,
	output logic [63:0]           read_data,
	output logic                  recorded,
	output logic                  flush_request
);

	localparam int unsigned AW = $clog2(AREA_DEPTH);
	localparam logic [31:0] DEPTH32 = 32'(AREA_DEPTH);
	localparam logic [covtr_pkg::AREA_W-1:0] DEPTH_CAP =
		(AREA_DEPTH > 8191) ? '1 : covtr_pkg::AREA_W'(AREA_DEPTH);
	localparam logic [AW-1:0] CLR_LAST = AW'(AREA_DEPTH - 1);

	// configuration and architectural state
	logic [1:0]                     mode_q;
	logic [covtr_pkg::AREA_W-1:0]   area_q;
	logic [63:0]                    offset_q;
	logic [63:0]                    prev_q;
	logic [AW-1:0]                  clr_ptr_q;

	// captured item
	covtr_pkg::covtr_kind_t kind_q;
	logic [63:0] loc_q;
	logic [2:0]  cmp_q;
	logic [63:0] opa_q;
	logic [63:0] opb_q;
	logic        in_range_q;
	logic [AW-1:0] waddr_q;
	logic [2:0]  bsel_q;

	// working registers
	logic [63:0]   rdata_q;
	logic [AW-1:0] ptr_q;
	logic [63:0]   cnt_q;
	logic [63:0]   res_data_q;
	logic          rec_q;
	logic          flush_q;
	logic [63:0]   prod_q;
	logic [63:0]   hash_q;
	logic [63:0]   out_data_q;
	logic          out_rec_q;
	logic          out_flush_q;

	// memory
	logic [63:0]   mem [AREA_DEPTH];
	logic          mem_we;
	logic [AW-1:0] mem_addr;
	logic [63:0]   mem_wdata;

	// combinational helpers
	logic [covtr_pkg::AREA_W-1:0] size;
	logic [15:0]   byte_mask;
	logic [15:0]   loc_lo;
	logic [15:0]   byte_idx;
	logic          in_range_in;
	covtr_pkg::covtr_kind_t kind_in;
	logic [AW-1:0] rd_addr_in;
	logic [63:0]   bumped;
	logic [63:0]   data_word;
	logic [63:0]   pos;
	logic [63:0]   cmp_limit;
	logic          cmp_fits;
	logic [31:0]   mul_a;
	logic [31:0]   mul_b;

	assign size = (area_q > DEPTH_CAP) ? DEPTH_CAP : area_q;

	// edge byte index from the incoming location
	assign byte_mask = {size, 3'b000} - 16'd1;
	assign loc_lo    = location[15:0] - offset_q[15:0];
	assign byte_idx  = (prev_q[15:0] ^ loc_lo) & byte_mask;

	assign in_range_in = {20'd0, read_index} < DEPTH32;

	// classify the incoming item
	always_comb begin
		priority if (req_type == covtr_pkg::REQ_READ) begin
			kind_in = covtr_pkg::KIND_READ;
		end else if (req_type == covtr_pkg::REQ_LOC && in_task_context &&
				mode_q == covtr_pkg::MODE_EDGE && size != '0) begin
			kind_in = covtr_pkg::KIND_EDGE;
		end else if (req_type == covtr_pkg::REQ_LOC && in_task_context &&
				mode_q == covtr_pkg::MODE_LOC) begin
			kind_in = covtr_pkg::KIND_LOC;
		end else if (req_type == covtr_pkg::REQ_CMP && in_task_context &&
				mode_q == covtr_pkg::MODE_CMP) begin
			kind_in = covtr_pkg::KIND_CMP;
		end else begin
			kind_in = covtr_pkg::KIND_NONE;
		end
	end

	// address of the read issued on transfer
	always_comb begin
		priority if (kind_in == covtr_pkg::KIND_READ) begin
			rd_addr_in = AW'(read_index);
		end else if (kind_in == covtr_pkg::KIND_EDGE) begin
			rd_addr_in = AW'(byte_idx[15:3]);
		end else begin
			rd_addr_in = '0;
		end
	end

	// increment one byte of the fetched word
	always_comb begin
		bumped = rdata_q;
		for (int b = 0; b < 8; b++) begin
			if (bsel_q == 3'(b)) begin
				bumped[8*b +: 8] = rdata_q[8*b +: 8] + 8'd1;
			end
		end
	end

	// data word for a trace append
	always_comb begin
		if (kind_q == covtr_pkg::KIND_LOC) begin
			data_word = loc_q;
		end else begin
			unique case (cmd.wsel)
				covtr_pkg::CW_TYPE: data_word = {61'd0, cmp_q};
				covtr_pkg::CW_A:    data_word = opa_q;
				covtr_pkg::CW_B:    data_word = opb_q;
				covtr_pkg::CW_LOC:  data_word = loc_q;
				default:            data_word = loc_q;
			endcase
		end
	end

	// append position and room checks
	assign pos       = rdata_q + 64'd1;
	assign cmp_limit = {51'd0, (size - covtr_pkg::CMP_REC_MIN) >> covtr_pkg::CMP_SHIFT};
	assign cmp_fits  = (size >= covtr_pkg::CMP_REC_MIN) && (rdata_q <= cmp_limit);

	// memory port selection
	always_comb begin
		mem_we    = 1'b0;
		mem_addr  = '0;
		mem_wdata = '0;
		priority if (cmd.accept) begin
			mem_addr = rd_addr_in;
		end else if (cmd.clear) begin
			mem_we   = 1'b1;
			mem_addr = clr_ptr_q;
		end else if (cmd.exec) begin
			mem_we    = (kind_q == covtr_pkg::KIND_EDGE);
			mem_addr  = waddr_q;
			mem_wdata = bumped;
		end else if (cmd.wr_data) begin
			mem_we    = 1'b1;
			mem_addr  = ptr_q;
			mem_wdata = data_word;
		end else if (cmd.wr_cnt) begin
			mem_we    = 1'b1;
			mem_wdata = cnt_q;
		end else begin
			mem_we = 1'b0;
		end
	end

	// single-port coverage memory with registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= mem_wdata;
		end
		if (cmd.accept) begin
			rdata_q <= mem[mem_addr];
		end
	end

	// hash multiplier operands, one 32x32 partial product per step
	always_comb begin
		unique case (cmd.mul_ph)
			covtr_pkg::MUL_LL: begin
				mul_a = loc_q[31:0];
				mul_b = covtr_pkg::HASH_MULT[31:0];
			end
			covtr_pkg::MUL_HL: begin
				mul_a = loc_q[63:32];
				mul_b = covtr_pkg::HASH_MULT[31:0];
			end
			covtr_pkg::MUL_LH: begin
				mul_a = loc_q[31:0];
				mul_b = covtr_pkg::HASH_MULT[63:32];
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// configuration, previous location hash and clearing pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= '0;
			area_q    <= covtr_pkg::AREA_RESET;
			offset_q  <= '0;
			prev_q    <= '0;
			clr_ptr_q <= '0;
		end else begin
			if (cfg_wr_en) begin
				unique case (cfg_index)
					covtr_pkg::REG_MODE: begin
						mode_q <= cfg_wdata[1:0];
						prev_q <= '0;
					end
					covtr_pkg::REG_AREA:   area_q   <= cfg_wdata[covtr_pkg::AREA_W-1:0];
					covtr_pkg::REG_OFFSET: offset_q <= cfg_wdata;
					default: ;
				endcase
			end
			if (cmd.mul_en && cmd.mul_ph == covtr_pkg::MUL_SUM) begin
				prev_q <= {hash_q[63:32] + prod_q[31:0], hash_q[31:0]};
			end
			if (cmd.clear) begin
				clr_ptr_q <= clr_ptr_q + AW'(1);
			end
		end
	end

	// capture the item on transfer
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			kind_q     <= kind_in;
			loc_q      <= location - offset_q;
			cmp_q      <= cmp_type;
			opa_q      <= operand_a;
			opb_q      <= operand_b;
			in_range_q <= in_range_in;
			waddr_q    <= AW'(byte_idx[15:3]);
			bsel_q     <= byte_idx[2:0];
		end
	end

	// evaluate the fetched word and form the result
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			res_data_q <= '0;
			rec_q      <= 1'b0;
			flush_q    <= 1'b0;
			cnt_q      <= pos;
			ptr_q      <= AW'(pos);
			unique case (kind_q)
				covtr_pkg::KIND_READ: res_data_q <= in_range_q ? rdata_q : '0;
				covtr_pkg::KIND_EDGE: rec_q <= 1'b1;
				covtr_pkg::KIND_LOC: begin
					flush_q <= (pos == {51'd0, size});
					rec_q   <= (pos < {51'd0, size});
				end
				covtr_pkg::KIND_CMP: begin
					rec_q <= cmp_fits;
					ptr_q <= AW'({rdata_q[61:0], 2'b01});
				end
				default: ;
			endcase
		end else if (cmd.wr_data) begin
			ptr_q <= ptr_q + AW'(1);
		end
	end

	// hash partial products and their sum
	always_ff @(posedge clk) begin
		if (cmd.mul_en) begin
			prod_q <= mul_a * mul_b;
			if (cmd.mul_ph == covtr_pkg::MUL_HL) begin
				hash_q <= prod_q;
			end else if (cmd.mul_ph == covtr_pkg::MUL_LH) begin
				hash_q[63:32] <= hash_q[63:32] + prod_q[31:0];
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_data_q  <= res_data_q;
			out_rec_q   <= rec_q;
			out_flush_q <= flush_q;
		end
	end

	assign read_data     = out_data_q;
	assign recorded      = out_rec_q;
	assign flush_request = out_flush_q;

	assign sts.kind     = kind_q;
	assign sts.rec      = rec_q;
	assign sts.clr_last = (clr_ptr_q == CLR_LAST);

endmodule

`default_nettype wire

>>> sv/covtr_checker.sv
// ----------------------------------------------------------------------------
// covtr_checker
// Port-level checks on the recorder, attached to the top level by bind.
// ----------------------------------------------------------------------------
`default_nettype none

`include "coverage_trace_recorder_assert.svh"

module covtr_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [63:0] read_data,
	input logic        recorded,
	input logic        flush_request
);

	// a stalled result holds
	`COVTR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(read_data) && $stable(recorded) && $stable(flush_request), "stalled result changed")

	// one item in flight: no transfer in the cycle after a transfer
	`COVTR_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready, "input taken twice in a row")

	// a full trace buffer is never also a recorded event
	`COVTR_ASSERT_NOW(a_flush_excl, out_valid, !(recorded && flush_request), "recorded with flush")

	// only reads return data, and reads change nothing
	`COVTR_ASSERT_NOW(a_read_only_data, out_valid && (read_data != 64'd0), !recorded && !flush_request, "data on an event result")

endmodule

bind coverage_trace_recorder covtr_checker u_covtr_checker (.*);

`default_nettype wire

>>> test/coverage_trace_recorder_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// coverage_trace_recorder_tb
// Self-checking bench for the coverage trace recorder. A scoreboard keeps its
// own copy of the coverage memory, previous edge hash and registers, predicts
// one result per accepted request, and compares results in order. Stimulus
// opens with a directed pass over the special cases, then runs phases of
// location and comparison tracing with areas sized around the current count,
// then edge bitmap phases, one of them aimed at a single byte until it wraps.
// Both channels idle at random.
// ----------------------------------------------------------------------------

localparam logic [1:0] MODE_OFF = 2'd0;
localparam logic [1:0] REQ_BAD = 2'd3;
localparam int unsigned MEM_WORDS = 4096;
localparam int unsigned CMP_WORDS = 4;

typedef struct packed {
	logic [1:0]  req;
	logic        from_task;
	logic [63:0] location;
	logic [2:0]  cmp;
	logic [63:0] op_a;
	logic [63:0] op_b;
	logic [11:0] index;
} cov_request_t;

typedef struct packed {
	logic [63:0] data;
	logic        rec;
	logic        flush;
} cov_result_t;

class coverage_scoreboard;
	logic [63:0] words [MEM_WORDS];
	logic [63:0] last_hash;
	logic [1:0]  mode;
	logic [12:0] area;
	logic [63:0] offset;
	cov_result_t expected_q [$];
	int unsigned errors, n_checked, n_rec, n_flush, n_read, n_wrap, n_live;

	function new();
		foreach (words[i]) words[i] = '0;
		last_hash = '0;
		mode = MODE_OFF;
		area = covtr_pkg::AREA_RESET;
		offset = '0;
		errors = 0;
		n_checked = 0;
		n_rec = 0;
		n_flush = 0;
		n_read = 0;
		n_wrap = 0;
		n_live = 0;
	endfunction

	function void set_register(logic [1:0] idx, logic [63:0] value);
		case (idx)
		covtr_pkg::REG_MODE: begin
			mode = value[1:0];
			last_hash = '0;
		end
		covtr_pkg::REG_AREA: area = value[12:0];
		covtr_pkg::REG_OFFSET: offset = value;
		default: ;
		endcase
	endfunction

	// words in use, capped at the memory depth
	function logic [63:0] span();
		return (area > MEM_WORDS) ? 64'(MEM_WORDS) : 64'(area);
	endfunction

	// location whose edge lands on byte_idx from the current hash
	function logic [63:0] aim(logic [63:0] byte_idx, logic [63:0] noise);
		logic [63:0] mask;
		mask = (span() << 3) - 64'd1;
		return ((noise & ~mask) | ((last_hash ^ byte_idx) & mask)) + offset;
	endfunction

	// predict the result of an accepted request and advance the memory
	function void note_request(cov_request_t r);
		cov_result_t e;
		logic [63:0] loc, sz, mask, bidx, pos, cnt, start;
		int unsigned w, sh;
		logic [7:0] b;
		e = '0;
		loc = r.location - offset;
		sz = span();
		if (r.req == covtr_pkg::REQ_READ) begin
			e.data = words[r.index];
			n_read++;
			n_live++;
		end else if (r.from_task && r.req == covtr_pkg::REQ_LOC &&
				mode == covtr_pkg::MODE_EDGE) begin
			n_live++;
			if (sz != 0) begin
				mask = (sz << 3) - 64'd1;
				bidx = (last_hash ^ loc) & mask;
				w = bidx[14:3];
				sh = 8 * bidx[2:0];
				b = words[w][sh +: 8] + 8'd1;
				if (b == 8'd0)
					n_wrap++;
				words[w][sh +: 8] = b;
				last_hash = loc * covtr_pkg::HASH_MULT;
				e.rec = 1'b1;
			end
		end else if (r.from_task && r.req == covtr_pkg::REQ_LOC &&
				mode == covtr_pkg::MODE_LOC) begin
			n_live++;
			pos = words[0] + 64'd1;
			e.flush = (pos == sz);
			if (pos < sz) begin
				words[pos[11:0]] = loc;
				words[0] = pos;
				e.rec = 1'b1;
			end
		end else if (r.from_task && r.req == covtr_pkg::REQ_CMP &&
				mode == covtr_pkg::MODE_CMP) begin
			n_live++;
			cnt = words[0];
			if (sz >= 1 + CMP_WORDS && cnt <= (sz - 1 - CMP_WORDS) / CMP_WORDS) begin
				start = 1 + cnt * CMP_WORDS;
				words[start[11:0]] = 64'(r.cmp);
				words[start[11:0] + 1] = r.op_a;
				words[start[11:0] + 2] = r.op_b;
				words[start[11:0] + 3] = loc;
				words[0] = cnt + 64'd1;
				e.rec = 1'b1;
			end
		end
		if (e.rec)
			n_rec++;
		if (e.flush)
			n_flush++;
		expected_q.push_back(e);
	endfunction

	task report(string what);
		errors++;
		if (errors <= 25)
			$display("[%0t] mismatch: %s", $time, what);
	endtask

	task check_result(cov_result_t got);
		cov_result_t e;
		n_checked++;
		if (expected_q.size() == 0) begin
			report($sformatf("result %0d arrived with no request outstanding", n_checked));
			return;
		end
		e = expected_q.pop_front();
		if (got.data !== e.data)
			report($sformatf("result %0d read_data %h, predicted %h", n_checked, got.data, e.data));
		if (got.rec !== e.rec)
			report($sformatf("result %0d recorded %b, predicted %b", n_checked, got.rec, e.rec));
		if (got.flush !== e.flush)
			report($sformatf("result %0d flush_request %b, predicted %b", n_checked, got.flush,
				e.flush));
	endtask
endclass

module coverage_trace_recorder_tb;
	localparam int unsigned CYCLE_LIMIT = 600000;
	localparam int unsigned TRACE_TARGET = 900;
	localparam int unsigned ITEM_TARGET = 1650;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  req_type;
	logic        in_task_context;
	logic [63:0] location;
	logic [2:0]  cmp_type;
	logic [63:0] operand_a;
	logic [63:0] operand_b;
	logic [11:0] read_index;
	logic        out_valid;
	logic        out_ready;
	logic [63:0] read_data;
	logic        recorded;
	logic        flush_request;
	logic        cfg_wr_en;
	logic [1:0]  cfg_index;
	logic [63:0] cfg_wdata;

	logic        calm = 1'b0;
	int unsigned cycles = 0;
	int unsigned n_phases = 0;
	int unsigned n_writes = 0;
	int unsigned n_sent = 0;
	coverage_scoreboard sb;

	coverage_trace_recorder dut (.*);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// watch transfers on both channels
	always @(posedge clk) begin
		if (arst_n === 1'b1) begin
			if (in_valid && in_ready)
				sb.note_request({req_type, in_task_context, location, cmp_type, operand_a,
					operand_b, read_index});
			if (out_valid && out_ready)
				sb.check_result({read_data, recorded, flush_request});
		end
	end

	// give up on a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("coverage_trace_recorder_tb: errors");
			$finish;
		end
	end

	// stall the result side: mostly short holds, now and then a long one
	initial begin
		int unsigned hold;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (!calm && $urandom_range(0, 99) < 30) begin
				out_ready = 1'b0;
				hold = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 3);
				repeat (hold) @(negedge clk);
			end else begin
				out_ready = 1'b1;
			end
		end
	end

	function automatic int unsigned next_gap();
		int unsigned roll;
		if (calm)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return 0;
		if (roll < 85)
			return $urandom_range(1, 3);
		if (roll < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	function automatic logic [63:0] wide_value();
		case ($urandom_range(0, 9))
		0: return '0;
		1: return '1;
		default: return {$urandom, $urandom};
		endcase
	endfunction

	function automatic logic [12:0] extreme_area();
		case ($urandom_range(0, 4))
		0: return 13'd0;
		1: return 13'd1;
		2: return 13'd2;
		3: return 13'd4096;
		default: return 13'd8191;
		endcase
	endfunction

	function automatic cov_request_t req_of(logic [1:0] req, logic from_task, logic [63:0] loc,
			logic [2:0] cmp, logic [63:0] a, logic [63:0] b, logic [11:0] idx);
		return '{req, from_task, loc, cmp, a, b, idx};
	endfunction

	// random request for the current mode; hot is the byte that edge events aim at
	function automatic cov_request_t random_item(logic [63:0] hot, int unsigned aim_pct,
			output bit aimed);
		cov_request_t r;
		logic [1:0] kind;
		logic [63:0] sz;
		int unsigned roll;
		sz = sb.span();
		aimed = 1'b0;
		if (sb.mode == covtr_pkg::MODE_CMP)
			kind = covtr_pkg::REQ_CMP;
		else if (sb.mode == MODE_OFF)
			kind = $urandom_range(0, 1) ? covtr_pkg::REQ_CMP : covtr_pkg::REQ_LOC;
		else
			kind = covtr_pkg::REQ_LOC;
		r = req_of(kind, 1'b1, wide_value(), 3'($urandom_range(0, 7)), wide_value(), wide_value(),
			12'($urandom_range(0, 4095)));
		roll = $urandom_range(0, 99);
		if (roll < 12) begin
			r.req = covtr_pkg::REQ_READ;
			if (aim_pct != 0 && $urandom_range(0, 1))
				r.index = hot[14:3];
			else if (sz != 0 && $urandom_range(0, 3) != 0)
				r.index = 12'($urandom_range(0, sz - 1));
		end else if (roll < 14) begin
			r.req = REQ_BAD;
		end else if (roll < 22) begin
			r.req = (kind == covtr_pkg::REQ_LOC) ? covtr_pkg::REQ_CMP : covtr_pkg::REQ_LOC;
			r.from_task = 1'($urandom_range(0, 1));
		end else begin
			r.from_task = (roll >= 28);
			aimed = r.from_task && sb.mode == covtr_pkg::MODE_EDGE &&
				$urandom_range(0, 99) < aim_pct;
		end
		return r;
	endfunction

	// offer one request and hold it until the transfer
	task automatic send(cov_request_t r, bit aimed = 1'b0, logic [63:0] hot = '0);
		int unsigned gap;
		gap = next_gap();
		@(negedge clk);
		if (gap != 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		// the hash is settled only once the previous transfer has been noted
		if (aimed)
			r.location = sb.aim(hot, r.location);
		{req_type, in_task_context, location, cmp_type, operand_a, operand_b, read_index} = r;
		in_valid = 1'b1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		n_sent++;
	endtask

	// drop valid and wait until every predicted result has been taken
	task automatic settle();
		@(negedge clk);
		in_valid = 1'b0;
		while (sb.expected_q.size() != 0) @(negedge clk);
		repeat (10) @(negedge clk);
	endtask

	task automatic write_register(logic [1:0] idx, logic [63:0] value);
		@(negedge clk);
		cfg_wr_en = 1'b1;
		cfg_index = idx;
		cfg_wdata = value;
		sb.set_register(idx, value);
		@(negedge clk);
		cfg_wr_en = 1'b0;
		n_writes++;
	endtask

	task automatic setup(logic [1:0] mode, logic [12:0] area, logic [63:0] offset);
		settle();
		write_register(covtr_pkg::REG_AREA, 64'(area));
		write_register(covtr_pkg::REG_OFFSET, offset);
		write_register(covtr_pkg::REG_MODE, 64'(mode));
	endtask

	task automatic run_phase(logic [1:0] mode, logic [12:0] area, int unsigned n,
			int unsigned aim_pct);
		cov_request_t r;
		logic [63:0] hot;
		bit aimed;
		setup(mode, area, wide_value());
		calm = ($urandom_range(0, 4) == 0);
		hot = (sb.span() == 0) ? 64'd0 : 64'($urandom_range(0, sb.span() * 8 - 1));
		repeat (n) begin
			r = random_item(hot, aim_pct, aimed);
			send(r, aimed, hot);
		end
		n_phases++;
	endtask

	initial begin
		logic [1:0] mode;
		logic [12:0] area;
		logic [63:0] want;
		int unsigned roll;
		sb = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		{req_type, in_task_context, location, cmp_type, operand_a, operand_b, read_index} = '0;
		cfg_wr_en = 1'b0;
		cfg_index = covtr_pkg::REG_MODE;
		cfg_wdata = '0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		// reset state: reads at both ends, an unknown request, an event with tracing off
		send(req_of(covtr_pkg::REQ_READ, 1'b0, '0, 3'd0, '0, '0, 12'd0));
		send(req_of(covtr_pkg::REQ_READ, 1'b1, '1, 3'd7, '1, '1, 12'hFFF));
		send(req_of(REQ_BAD, 1'b1, '1, 3'd7, '1, '1, 12'hFFF));
		send(req_of(covtr_pkg::REQ_LOC, 1'b1, 64'h1234, 3'd0, '0, '0, 12'd0));

		// location trace in a four-word area: fill, then flag full twice
		setup(covtr_pkg::MODE_LOC, 13'd4, 64'h10);
		send(req_of(covtr_pkg::REQ_LOC, 1'b0, 64'h55, 3'd0, '0, '0, 12'd0));
		send(req_of(covtr_pkg::REQ_CMP, 1'b1, 64'h55, 3'd1, '1, '1, 12'd0));
		send(req_of(covtr_pkg::REQ_LOC, 1'b1, '1, 3'd0, '0, '0, 12'd0));
		send(req_of(covtr_pkg::REQ_LOC, 1'b1, 64'h10, 3'd0, '0, '0, 12'd0));
		send(req_of(covtr_pkg::REQ_LOC, 1'b1, 64'h0, 3'd0, '0, '0, 12'd0));
		send(req_of(covtr_pkg::REQ_LOC, 1'b1, 64'hDEAD_BEEF, 3'd0, '0, '0, 12'd0));
		send(req_of(covtr_pkg::REQ_LOC, 1'b1, 64'hBEEF_DEAD, 3'd0, '0, '0, 12'd0));
		send(req_of(covtr_pkg::REQ_READ, 1'b0, '0, 3'd0, '0, '0, 12'd1));
		send(req_of(covtr_pkg::REQ_READ, 1'b0, '0, 3'd0, '0, '0, 12'd3));

		// zero area finds no room
		setup(covtr_pkg::MODE_LOC, 13'd0, 64'h10);
		send(req_of(covtr_pkg::REQ_LOC, 1'b1, 64'h77, 3'd0, '0, '0, 12'd0));

		// comparison records with the area clipped to the memory depth
		setup(covtr_pkg::MODE_CMP, 13'd8191, '1);
		send(req_of(covtr_pkg::REQ_CMP, 1'b1, 64'h0, 3'd7, '1, '0, 12'd0));
		send(req_of(covtr_pkg::REQ_CMP, 1'b1, '1, 3'd0, '0, '1, 12'd0));
		send(req_of(covtr_pkg::REQ_LOC, 1'b1, 64'h99, 3'd0, '0, '0, 12'd0));
		send(req_of(covtr_pkg::REQ_READ, 1'b0, '0, 3'd0, '0, '0, 12'd0));
		send(req_of(covtr_pkg::REQ_READ, 1'b0, '0, 3'd0, '0, '0, 12'd16));

		// record that does not fit
		setup(covtr_pkg::MODE_CMP, 13'd20, '0);
		send(req_of(covtr_pkg::REQ_CMP, 1'b1, 64'h42, 3'd3, 64'h1, 64'h2, 12'd0));

		// edge event with zero area is ignored
		setup(covtr_pkg::MODE_EDGE, 13'd0, '0);
		send(req_of(covtr_pkg::REQ_LOC, 1'b1, 64'h42, 3'd0, '0, '0, 12'd0));
		send(req_of(covtr_pkg::REQ_READ, 1'b0, '0, 3'd0, '0, '0, 12'd0));

		// trace phases, area sized around the current count so that buffers fill up
		while (n_sent < TRACE_TARGET) begin
			roll = $urandom_range(0, 9);
			mode = (roll < 4) ? covtr_pkg::MODE_LOC :
				(roll < 8) ? covtr_pkg::MODE_CMP : MODE_OFF;
			if ($urandom_range(0, 7) == 0)
				want = 64'(extreme_area());
			else if (mode == covtr_pkg::MODE_CMP)
				want = 1 + CMP_WORDS * sb.words[0] + CMP_WORDS * $urandom_range(0, 10)
					+ $urandom_range(0, 3);
			else
				want = sb.words[0] + 1 + $urandom_range(0, 40);
			area = (want > 64'd8191) ? 13'd8191 : want[12:0];
			run_phase(mode, area, $urandom_range(30, 70), 0);
		end

		// edge bitmap: hammer one byte of a two-word area past its wrap
		run_phase(covtr_pkg::MODE_EDGE, 13'd2, 420, 100);

		// edge bitmap over assorted areas, odd sizes among them
		while (n_sent < ITEM_TARGET) begin
			case ($urandom_range(0, 9))
			0, 1: area = extreme_area();
			2, 3: area = 13'($urandom_range(1, 4096));
			default: area = 13'd1 << $urandom_range(1, 12);
			endcase
			mode = ($urandom_range(0, 4) == 0) ? MODE_OFF : covtr_pkg::MODE_EDGE;
			run_phase(mode, area, $urandom_range(30, 70), 35);
		end

		settle();
		$display("%0d results checked (%0d live) over %0d phases and %0d register writes",
			sb.n_checked, sb.n_live, n_phases, n_writes);
		$display("%0d recorded events, %0d flushes, %0d reads, %0d byte wraps",
			sb.n_rec, sb.n_flush, sb.n_read, sb.n_wrap);
		if (sb.errors == 0)
			$display("coverage_trace_recorder_tb: clean");
		else
			$display("coverage_trace_recorder_tb: errors");
		$finish;
	end
endmodule
